// File: src/wpas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpas_pkg
// Shared types and constants of the waypoint arrival sequencer.
// ----------------------------------------------------------------------------
package wpas_pkg;

  localparam int NUM_GOALS  = 16;
  localparam int NUM_JOINTS = 7;

  localparam int ANGLE_W = 16;
  localparam int POSE_W  = NUM_JOINTS * ANGLE_W;
  localparam int IDX_W   = $clog2(NUM_GOALS);
  localparam int CNT_W   = $clog2(NUM_GOALS + 1);
  localparam int OUT_CNT_W = 5;
  localparam int DIFF_W  = ANGLE_W + 1;
  localparam int SQ_W    = 2 * ANGLE_W;
  localparam int DSQ_W   = 35;

  localparam logic [DSQ_W-1:0] THRESH_RESET = DSQ_W'(419);

  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_SAMPLE = 2'd1;
  localparam logic [1:0] REQ_ACK    = 2'd2;

  typedef struct packed {
    logic [1:0]                req_type;
    logic signed [ANGLE_W-1:0] joint_0;
    logic signed [ANGLE_W-1:0] joint_1;
    logic signed [ANGLE_W-1:0] joint_2;
    logic signed [ANGLE_W-1:0] joint_3;
    logic signed [ANGLE_W-1:0] joint_4;
    logic signed [ANGLE_W-1:0] joint_5;
    logic signed [ANGLE_W-1:0] joint_6;
  } wpas_req_t;

  typedef struct packed {
    logic                 reached;
    logic                 all_done;
    logic [OUT_CNT_W-1:0] target_index;
    logic [OUT_CNT_W-1:0] goals_loaded;
    logic [DSQ_W-1:0]     dist_sq;
  } wpas_rsp_t;

endpackage

// File: src/wpas_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpas_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface wpas_req_if
  import wpas_pkg::*;
();
  logic      valid;
  logic      ready;
  wpas_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface wpas_rsp_if
  import wpas_pkg::*;
();
  logic      valid;
  logic      ready;
  wpas_rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: src/waypoint_arrival_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waypoint_arrival_sequencer
// Goal pose table with squared-distance arrival detection.
// ----------------------------------------------------------------------------
// One item is processed at a time and every item gives one result item. A
// load, acknowledge or ignored item passes through the accepting cycle and
// the state that registers the result. A joint sample that is compared passes
// through the accepting cycle, which also reads the goal memory, a state for
// the seven squarers, one for the sum and one for the compare and the result
// register. The next item is accepted in the cycle after the result is
// registered, while that result may still wait in the output register. A
// result that is still waiting holds the block in its last state until the
// output register frees.
module waypoint_arrival_sequencer
  import wpas_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  wpas_req_if.sink             in_i,
  wpas_rsp_if.source           out_o,
  input  logic                 cfg_we_i,
  input  logic [DSQ_W-1:0]     cfg_wdata_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_SUM  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [DSQ_W-1:0]      thr_q;
  logic [CNT_W-1:0]      loaded_q, loaded_d;
  logic [CNT_W-1:0]      index_q, index_d;
  logic                  reached_q, reached_d;
  logic                  done_q, done_d;
  logic                  out_valid_q, out_valid_d;
  wpas_rsp_t             out_q;

  logic [1:0]                req_q;
  logic                      cmp_q;
  logic signed [ANGLE_W-1:0] joints_q [NUM_JOINTS];
  logic [SQ_W-1:0]           sq_q [NUM_JOINTS];
  logic [SQ_W-1:0]           sq_d [NUM_JOINTS];
  logic [DSQ_W-1:0]          dsq_q, dsq_d;

  logic [POSE_W-1:0] mem [NUM_GOALS];
  logic [POSE_W-1:0] rdata_q;
  logic [POSE_W-1:0] wdata;
  logic              accept, mem_we, mem_re, cmp_d, out_free;

  assign in_i.ready    = (state_q == ST_IDLE);
  assign accept        = in_i.valid && in_i.ready;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;
  assign out_free      = !out_valid_q || out_o.ready;

  assign wdata = {in_i.payload.joint_6, in_i.payload.joint_5, in_i.payload.joint_4,
                  in_i.payload.joint_3, in_i.payload.joint_2, in_i.payload.joint_1,
                  in_i.payload.joint_0};

  assign mem_we = accept && (in_i.payload.req_type == REQ_LOAD) &&
                  (loaded_q < CNT_W'(NUM_GOALS));
  assign cmp_d  = (in_i.payload.req_type == REQ_SAMPLE) &&
                  (loaded_q == CNT_W'(NUM_GOALS)) && (index_q < CNT_W'(NUM_GOALS));
  assign mem_re = accept && cmp_d;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[loaded_q[IDX_W-1:0]] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[index_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q       <= in_i.payload.req_type;
      cmp_q       <= cmp_d;
      joints_q[0] <= in_i.payload.joint_0;
      joints_q[1] <= in_i.payload.joint_1;
      joints_q[2] <= in_i.payload.joint_2;
      joints_q[3] <= in_i.payload.joint_3;
      joints_q[4] <= in_i.payload.joint_4;
      joints_q[5] <= in_i.payload.joint_5;
      joints_q[6] <= in_i.payload.joint_6;
    end
    if (state_q == ST_READ) begin
      sq_q <= sq_d;
    end
    if (state_q == ST_SUM) begin
      dsq_q <= dsq_d;
    end else if (accept) begin
      dsq_q <= '0;
    end
    if ((state_q == ST_FIN) && out_free) begin
      out_q.reached      <= reached_d;
      out_q.all_done     <= done_d;
      out_q.target_index <= OUT_CNT_W'(index_d);
      out_q.goals_loaded <= OUT_CNT_W'(loaded_d);
      out_q.dist_sq      <= dsq_q;
    end
  end

  always_comb begin
    logic signed [DIFF_W-1:0]   diff;
    logic signed [2*DIFF_W-1:0] prod;
    for (int j = 0; j < NUM_JOINTS; j++) begin
      diff    = DIFF_W'(joints_q[j]) - DIFF_W'($signed(rdata_q[j*ANGLE_W +: ANGLE_W]));
      prod    = diff * diff;
      sq_d[j] = prod[SQ_W-1:0];
    end
  end

  always_comb begin
    dsq_d = '0;
    for (int j = 0; j < NUM_JOINTS; j++) begin
      dsq_d = dsq_d + DSQ_W'(sq_q[j]);
    end
  end

  always_comb begin
    loaded_d  = loaded_q;
    index_d   = index_q;
    reached_d = reached_q;
    done_d    = done_q;
    case (req_q)
      REQ_LOAD: begin
        if (loaded_q < CNT_W'(NUM_GOALS)) begin
          loaded_d = loaded_q + CNT_W'(1);
        end
      end
      REQ_SAMPLE: begin
        if (cmp_q) begin
          if (dsq_q < thr_q) begin
            if ((index_q != '0) && !index_q[0]) begin
              reached_d = 1'b1;
            end
            index_d = index_q + CNT_W'(1);
          end else begin
            reached_d = 1'b0;
          end
        end else if ((loaded_q == CNT_W'(NUM_GOALS)) && (index_q >= CNT_W'(NUM_GOALS))) begin
          done_d = 1'b1;
        end
      end
      REQ_ACK: begin
        reached_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = cmp_d ? ST_READ : ST_FIN;
        end
      end
      ST_READ: begin
        state_d = ST_SUM;
      end
      ST_SUM: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      thr_q       <= THRESH_RESET;
      loaded_q    <= '0;
      index_q     <= '0;
      reached_q   <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if ((state_q == ST_FIN) && out_free) begin
        loaded_q  <= loaded_d;
        index_q   <= index_d;
        reached_q <= reached_d;
        done_q    <= done_d;
      end
    end
  end

endmodule

// File: src/wpas_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpas_checker
// Port-level properties of the waypoint arrival sequencer.
// ----------------------------------------------------------------------------
module wpas_checker
  import wpas_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input wpas_rsp_t       out_payload_i
);

  localparam logic [OUT_CNT_W-1:0] FULL = OUT_CNT_W'(NUM_GOALS);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_payload_i))
    else $error("Result item changed while stalled.");

  a_dist_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_payload_i.dist_sq != '0) |-> out_payload_i.goals_loaded == FULL)
    else $error("Distance reported before the goal table was full.");

  a_done_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_payload_i.all_done |-> out_payload_i.target_index == FULL)
    else $error("Done reported before the last goal was reached.");

  a_reached_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_payload_i.reached |-> out_payload_i.target_index >= OUT_CNT_W'(3))
    else $error("Reached reported at too low a goal index.");

endmodule

bind waypoint_arrival_sequencer wpas_checker u_wpas_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_payload_i (out_o.payload)
);

// File: tb/waypoint_arrival_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waypoint_arrival_sequencer_tb
// Self-checking testbench for the waypoint arrival sequencer. A short table of
// directed items fills the goal table and exercises the edge cases. Random
// phases follow, each under its own arrival threshold, with many samples placed
// near the current goal. A behavioral model predicts each result item that the
// directed table does not give, and both channels idle and stall at random.
// ----------------------------------------------------------------------------
module waypoint_arrival_sequencer_tb;
  import wpas_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int ITEMS_PER_PHASE = 230;
  localparam int NUM_PHASES = 6;
  localparam int MAX_WAIT = 17;
  localparam logic [DSQ_W-1:0] THRESH_MAX = {DSQ_W{1'b1}};
  localparam logic [DSQ_W-1:0] FULL_SWING_DSQ = DSQ_W'(64'd30063853575);

  typedef logic signed [ANGLE_W-1:0] pose_t [NUM_JOINTS];

  typedef struct {
    wpas_req_t req;
    bit        typed;
    wpas_rsp_t want;
  } stim_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [DSQ_W-1:0] cfg_wdata_i;

  wpas_req_if req_if ();
  wpas_rsp_if rsp_if ();

  waypoint_arrival_sequencer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (req_if),
    .out_o       (rsp_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  logic signed [ANGLE_W-1:0] goal_tbl [NUM_GOALS][NUM_JOINTS];
  int unsigned      n_loaded;
  int unsigned      tgt_idx;
  bit               reached_q;
  bit               done_q;
  logic [DSQ_W-1:0] arrive_thresh;

  wpas_rsp_t pending_status_q [$];

  bit calm_tx;
  bit calm_rx;
  int n_errors;
  int n_items;
  int n_checked;
  int n_arrivals;
  int n_misses;
  int n_settings;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    n_errors++;
  endtask

  function automatic wpas_req_t make_req(input logic [1:0] kind, input pose_t p);
    wpas_req_t r;
    r.req_type = kind;
    r.joint_0  = p[0];
    r.joint_1  = p[1];
    r.joint_2  = p[2];
    r.joint_3  = p[3];
    r.joint_4  = p[4];
    r.joint_5  = p[5];
    r.joint_6  = p[6];
    return r;
  endfunction

  function automatic wpas_rsp_t status(input bit rch, input bit dn, input int idx,
                                       input int ld, input logic [DSQ_W-1:0] dsq);
    wpas_rsp_t s;
    s.reached      = rch;
    s.all_done     = dn;
    s.target_index = OUT_CNT_W'(idx);
    s.goals_loaded = OUT_CNT_W'(ld);
    s.dist_sq      = dsq;
    return s;
  endfunction

  function automatic logic [DSQ_W-1:0] pose_error_sq(input wpas_req_t r, input int unsigned gi);
    logic signed [ANGLE_W-1:0] j [NUM_JOINTS];
    longint d;
    longint sum;
    j = '{r.joint_0, r.joint_1, r.joint_2, r.joint_3, r.joint_4, r.joint_5, r.joint_6};
    sum = 0;
    for (int k = 0; k < NUM_JOINTS; k++) begin
      d = longint'(j[k]) - longint'(goal_tbl[gi][k]);
      sum += d * d;
    end
    return sum[DSQ_W-1:0];
  endfunction

  function automatic wpas_rsp_t step_sequencer(input wpas_req_t r);
    logic [DSQ_W-1:0] dsq;
    dsq = '0;
    case (r.req_type)
      REQ_LOAD: begin
        if (n_loaded < NUM_GOALS) begin
          goal_tbl[n_loaded] = '{r.joint_0, r.joint_1, r.joint_2, r.joint_3,
                                 r.joint_4, r.joint_5, r.joint_6};
          n_loaded++;
        end
      end
      REQ_SAMPLE: begin
        if (n_loaded == NUM_GOALS) begin
          if (tgt_idx < NUM_GOALS) begin
            dsq = pose_error_sq(r, tgt_idx);
            if (dsq < arrive_thresh) begin
              if (tgt_idx != 0 && tgt_idx % 2 == 0) reached_q = 1'b1;
              tgt_idx++;
              n_arrivals++;
            end else begin
              reached_q = 1'b0;
              n_misses++;
            end
          end else begin
            done_q = 1'b1;
          end
        end
      end
      REQ_ACK: begin
        reached_q = 1'b0;
      end
      default: begin
      end
    endcase
    return status(reached_q, done_q, tgt_idx, n_loaded, dsq);
  endfunction

  function automatic logic signed [ANGLE_W-1:0] near(input logic signed [ANGLE_W-1:0] g,
                                                     input int unsigned span);
    return g + ANGLE_W'($urandom_range(0, 2 * span)) - ANGLE_W'(span);
  endfunction

  function automatic wpas_req_t random_req();
    pose_t       p;
    int          roll;
    int          pick;
    int unsigned span;
    int unsigned gi;
    roll = $urandom_range(0, 99);
    pick = $urandom_range(0, 99);
    span = (pick < 5) ? 0 : (pick < 20) ? 1 : (pick < 40) ? 8 : 64;
    gi = (tgt_idx < NUM_GOALS) ? tgt_idx : $urandom_range(0, NUM_GOALS - 1);
    foreach (p[k]) p[k] = ANGLE_W'($urandom);
    if (roll < 6) return make_req(REQ_LOAD, p);
    if (roll < 18) return make_req(REQ_ACK, p);
    if (roll < 22) return make_req(REQ_UNUSED, p);
    if (n_loaded == NUM_GOALS && pick < 65) begin
      foreach (p[k]) p[k] = near(goal_tbl[gi][k], span);
    end
    return make_req(REQ_SAMPLE, p);
  endfunction

  task automatic send_item(input wpas_req_t r, input bit typed, input wpas_rsp_t want);
    int gap;
    wpas_rsp_t pred;
    gap = calm_tx ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= r;
    do @(posedge clk_i); while (!req_if.ready);
    pred = step_sequencer(r);
    pending_status_q.insert(pending_status_q.size(), typed ? want : pred);
    n_items++;
  endtask

  task automatic write_threshold(input logic [DSQ_W-1:0] value);
    req_if.valid <= 1'b0;
    while (pending_status_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    arrive_thresh = value;
    n_settings++;
  endtask

  initial begin
    int stall;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = calm_rx ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
    end
  end

  always @(posedge clk_i) begin
    wpas_rsp_t want;
    wpas_rsp_t got;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got = rsp_if.payload;
      if (pending_status_q.size() == 0) begin
        report("result item with no request outstanding");
      end else begin
        want = pending_status_q.pop_front();
        n_checked++;
        if (got.reached !== want.reached)
          report($sformatf("reached %b, want %b", got.reached, want.reached));
        if (got.all_done !== want.all_done)
          report($sformatf("all_done %b, want %b", got.all_done, want.all_done));
        if (got.target_index !== want.target_index)
          report($sformatf("target_index %0d, want %0d", got.target_index,
                           want.target_index));
        if (got.goals_loaded !== want.goals_loaded)
          report($sformatf("goals_loaded %0d, want %0d", got.goals_loaded,
                           want.goals_loaded));
        if (got.dist_sq !== want.dist_sq)
          report($sformatf("dist_sq %0d, want %0d", got.dist_sq, want.dist_sq));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    stim_row_t        rows [$];
    pose_t            goals [NUM_GOALS];
    pose_t            p;
    logic [DSQ_W-1:0] phase_thresh [NUM_PHASES];

    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    calm_tx        = 1'b0;
    calm_rx        = 1'b0;
    n_loaded       = 0;
    tgt_idx        = 0;
    reached_q      = 1'b0;
    done_q         = 1'b0;
    arrive_thresh  = THRESH_RESET;
    foreach (goal_tbl[g, k]) goal_tbl[g][k] = '0;

    foreach (p[k]) p[k] = '0;
    rows.insert(rows.size(), '{make_req(REQ_SAMPLE, p), 1'b1, status(0, 0, 0, 0, '0)});
    rows.insert(rows.size(), '{make_req(REQ_ACK, p), 1'b1, status(0, 0, 0, 0, '0)});
    foreach (p[k]) p[k] = ANGLE_W'($urandom);
    rows.insert(rows.size(), '{make_req(REQ_UNUSED, p), 1'b1, status(0, 0, 0, 0, '0)});
    for (int g = 0; g < NUM_GOALS; g++) begin
      foreach (p[k])
        p[k] = (g == 0) ? 16'sh8000 : ((g == 1) ? 16'sh7FFF : ANGLE_W'($urandom));
      goals[g] = p;
      rows.insert(rows.size(), '{make_req(REQ_LOAD, p), 1'b1, status(0, 0, 0, g + 1, '0)});
    end
    foreach (p[k]) p[k] = ANGLE_W'($urandom);
    rows.insert(rows.size(),
                '{make_req(REQ_LOAD, p), 1'b1, status(0, 0, 0, NUM_GOALS, '0)});
    foreach (p[k]) p[k] = 16'sh7FFF;
    rows.insert(rows.size(), '{make_req(REQ_SAMPLE, p), 1'b1,
                               status(0, 0, 0, NUM_GOALS, FULL_SWING_DSQ)});
    rows.insert(rows.size(),
                '{make_req(REQ_SAMPLE, goals[0]), 1'b1, status(0, 0, 1, NUM_GOALS, '0)});
    rows.insert(rows.size(),
                '{make_req(REQ_SAMPLE, goals[1]), 1'b1, status(0, 0, 2, NUM_GOALS, '0)});
    rows.insert(rows.size(), '{make_req(REQ_SAMPLE, goals[2]), 1'b0, '0});
    rows.insert(rows.size(), '{make_req(REQ_SAMPLE, goals[3]), 1'b0, '0});
    rows.insert(rows.size(), '{make_req(REQ_ACK, goals[3]), 1'b0, '0});

    phase_thresh = '{'0, DSQ_W'(1), DSQ_W'($urandom_range(2, 4096)), THRESH_RESET,
                     THRESH_MAX, DSQ_W'({$urandom, $urandom})};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_item(rows[i].req, rows[i].typed, rows[i].want);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_threshold(phase_thresh[ph]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 64 == 0) begin
          calm_tx = ($urandom_range(0, 3) == 0);
          calm_rx = ($urandom_range(0, 3) == 0);
        end
        send_item(random_req(), 1'b0, '0);
      end
    end

    req_if.valid <= 1'b0;
    while (pending_status_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Run covered %0d items and %0d checked results under %0d threshold settings.",
             n_items, n_checked, n_settings + 1);
    $display("Goal comparisons: %0d arrivals, %0d misses; final goal %0d, done %0b.",
             n_arrivals, n_misses, tgt_idx, done_q);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
